// ----- hdl/vrc_pkg.sv -----
package vrc_pkg;

  // Input word modes.
  localparam logic [1:0] MODE_SAMPLE = 2'd0;
  localparam logic [1:0] MODE_RESET  = 2'd1;
  localparam logic [1:0] MODE_STOP   = 2'd2;

  // Configuration register indexes.
  localparam logic CFG_SENSITIVITY = 1'b0;
  localparam logic CFG_ENABLE      = 1'b1;

  // Direction codes kept between samples.
  localparam logic [1:0] DIR_NONE = 2'd0;
  localparam logic [1:0] DIR_UP   = 2'd1;
  localparam logic [1:0] DIR_DOWN = 2'd2;

  localparam logic [6:0]  REST_GAP_MAX_MS = 7'd100;
  localparam logic [15:0] STILL_SPEED     = 16'd80;
  localparam logic [31:0] STILL_HOLD_MS   = 32'd300;
  localparam logic [9:0]  REP_MAX         = 10'd1023;

  // Threshold tables, one row per sensitivity level.
  localparam logic [15:0] DIR_THR   [4] = '{16'd350, 16'd220, 16'd120, 16'd60};
  localparam logic [15:0] GYRO_THR  [4] = '{16'd150, 16'd100, 16'd60, 16'd30};
  localparam logic [15:0] START_THR [4] = '{16'd400, 16'd280, 16'd180, 16'd100};
  localparam logic [15:0] REP_GAP   [4] = '{16'd600, 16'd450, 16'd350, 16'd250};

  typedef struct packed {
    logic        have_last_sample;
    logic [31:0] last_sample_time;
    logic        in_set;
    logic [31:0] set_start_time;
    logic [31:0] set_elapsed;
    logic [31:0] rest_accum;
    logic [9:0]  rep_total;
    logic [15:0] peak_abs_speed;
    logic [1:0]  last_direction;
    logic [31:0] last_rep_time;
    logic        still_active;
    logic [31:0] still_start_time;
  } state_t;

  typedef struct packed {
    logic        ignored;
    logic        set_active;
    logic        set_started;
    logic        rep_event;
    logic [9:0]  rep_count;
    logic [31:0] total_time_ms;
    logic [31:0] rest_time_ms;
    logic [15:0] peak_speed;
    logic        zero_velocity_request;
  } result_t;

endpackage

// ----- hdl/vrc_step.sv -----
module vrc_step #(
  parameter int VELOCITY_BITS = 16
) (
  input  vrc_pkg::state_t                  state,
  input  logic                             enable,
  input  logic [1:0]                       level,
  input  logic [1:0]                       mode,
  input  logic signed [VELOCITY_BITS-1:0]  velocity,
  input  logic [15:0]                      gyro_magnitude,
  input  logic [31:0]                      now_ms,
  output vrc_pkg::state_t                  state_next,
  output logic                             clear_enable,
  output vrc_pkg::result_t                 result
);

  localparam int CW = (VELOCITY_BITS > 16) ? VELOCITY_BITS : 16;

  logic                     neg;
  logic [VELOCITY_BITS-1:0] vabs;
  logic [CW-1:0]            vabs_w;
  logic                     gyro_act;
  logic                     fast_dir;
  logic                     start;
  logic [31:0]              last_time;
  logic [31:0]              gap_full;
  logic [6:0]               gap;
  logic [32:0]              rest_sum;
  logic [1:0]               dir;
  vrc_pkg::state_t          base;

  assign neg      = velocity[VELOCITY_BITS-1];
  assign vabs     = neg ? (VELOCITY_BITS'(~velocity) + VELOCITY_BITS'(1)) : velocity;
  assign vabs_w   = CW'(vabs);
  assign gyro_act = gyro_magnitude > vrc_pkg::GYRO_THR[level];
  assign fast_dir = vabs_w > CW'(vrc_pkg::DIR_THR[level]);
  assign start    = !state.in_set && (vabs_w >= CW'(vrc_pkg::START_THR[level])) && gyro_act;

  assign last_time = state.have_last_sample ? state.last_sample_time : now_ms;
  assign gap_full  = now_ms - last_time;
  assign gap       = (gap_full > 32'(vrc_pkg::REST_GAP_MAX_MS)) ? vrc_pkg::REST_GAP_MAX_MS
                                                                : gap_full[6:0];

  always_comb begin
    base = state;
    base.have_last_sample = 1'b1;
    base.last_sample_time = now_ms;
    if (start) begin
      base.in_set         = 1'b1;
      base.set_start_time = now_ms;
      base.set_elapsed    = '0;
      base.rest_accum     = '0;
      base.rep_total      = '0;
      base.peak_abs_speed = '0;
      base.last_direction = vrc_pkg::DIR_NONE;
      base.last_rep_time  = '0;
      base.still_active   = 1'b0;
    end
  end

  always_comb begin
    if (fast_dir && !neg) begin
      dir = vrc_pkg::DIR_UP;
    end else if (fast_dir && neg) begin
      dir = vrc_pkg::DIR_DOWN;
    end else begin
      dir = vrc_pkg::DIR_NONE;
    end
  end

  assign rest_sum = {1'b0, base.rest_accum} + 33'(gap);

  always_comb begin
    state_next   = state;
    clear_enable = 1'b0;
    result       = '0;
    case (mode)
      vrc_pkg::MODE_RESET: begin
        state_next = '0;
        result.zero_velocity_request = 1'b1;
      end
      vrc_pkg::MODE_STOP: begin
        clear_enable      = 1'b1;
        state_next.in_set = 1'b0;
      end
      vrc_pkg::MODE_SAMPLE: begin
        if (!enable) begin
          result.ignored = 1'b1;
        end else begin
          state_next = base;
          result.set_started = start;
          if (base.in_set) begin
            state_next.set_elapsed = now_ms - base.set_start_time;
            if (vabs_w > CW'(base.peak_abs_speed)) begin
              state_next.peak_abs_speed = (vabs_w > CW'(16'hFFFF)) ? 16'hFFFF : vabs_w[15:0];
            end
            if (dir != vrc_pkg::DIR_NONE) begin
              if (dir == vrc_pkg::DIR_UP && base.last_direction == vrc_pkg::DIR_DOWN &&
                  (now_ms - base.last_rep_time) >= 32'(vrc_pkg::REP_GAP[level]) &&
                  gyro_act) begin
                if (base.rep_total < vrc_pkg::REP_MAX) begin
                  state_next.rep_total = base.rep_total + 10'd1;
                end
                state_next.last_rep_time = now_ms;
                result.rep_event = 1'b1;
              end
              state_next.last_direction = dir;
            end
            if (!(vabs_w > CW'(vrc_pkg::STILL_SPEED) || gyro_act)) begin
              state_next.rest_accum = rest_sum[32] ? 32'hFFFF_FFFF : rest_sum[31:0];
            end
            if (vabs_w < CW'(vrc_pkg::STILL_SPEED) && !gyro_act) begin
              if (!base.still_active) begin
                state_next.still_active     = 1'b1;
                state_next.still_start_time = now_ms;
              end else if ((now_ms - base.still_start_time) >= vrc_pkg::STILL_HOLD_MS) begin
                result.zero_velocity_request = 1'b1;
              end
            end else begin
              state_next.still_active = 1'b0;
            end
          end
        end
      end
      default: begin
        state_next = state;
      end
    endcase
    result.set_active    = state_next.in_set;
    result.rep_count     = state_next.rep_total;
    result.total_time_ms = state_next.set_elapsed;
    result.rest_time_ms  = state_next.rest_accum;
    result.peak_speed    = state_next.peak_abs_speed;
  end

endmodule

// ----- hdl/vrc_state.sv -----
module vrc_state (
  input  logic            clk,
  input  logic            rst,
  input  logic            step,
  input  vrc_pkg::state_t state_next,
  input  logic            clear_enable,
  input  logic            cfg_we,
  input  logic            cfg_index,
  input  logic [1:0]      cfg_data,
  output vrc_pkg::state_t state,
  output logic            enable,
  output logic [1:0]      level
);

  // State follows step; user must do configuration writes while idle (unchecked).
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= '0;
      enable <= 1'b0;
      level  <= 2'd2;
    end else begin
      if (step) begin
        state <= state_next;
        if (clear_enable) begin
          enable <= 1'b0;
        end
      end
      if (cfg_we) begin
        if (cfg_index == vrc_pkg::CFG_SENSITIVITY) begin
          level <= cfg_data;
        end else begin
          enable <= cfg_data[0];
          if (cfg_data[0]) begin
            state.have_last_sample <= 1'b0;
          end
        end
      end
    end
  end

endmodule

// ----- hdl/velocity_rep_counter_top.sv -----
// Repetition counter for a lifting workout. Each input word is one timestamped sample
// (vertical velocity in mm/s, gyro magnitude in 0.1 deg/s, millisecond time) or a command
// (mode 1 clears all set state, mode 2 stops the workout and ends the set). Every input
// word yields exactly one output word with the set status, rep count, set time, rest time,
// peak speed and event flags. The block takes one word per clock while the output side is
// not stalled: a word is held in the input register, the update logic runs combinationally
// against the set state, and the result is loaded into the output register. Write the
// sensitivity level (index 0) and enable (index 1) only while no word is in flight.
module velocity_rep_counter_top #(
  parameter int VELOCITY_BITS = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  // Sample channel.
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [1:0]                      mode,
  input  logic signed [VELOCITY_BITS-1:0] velocity,
  input  logic [15:0]                     gyro_magnitude,
  input  logic [31:0]                     now_ms,
  // Result channel.
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            ignored,
  output logic                            set_active,
  output logic                            set_started,
  output logic                            rep_event,
  output logic [9:0]                      rep_count,
  output logic [31:0]                     total_time_ms,
  output logic [31:0]                     rest_time_ms,
  output logic [15:0]                     peak_speed,
  output logic                            zero_velocity_request,
  // Configuration channel.
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic                            cfg_index,
  input  logic [1:0]                      cfg_data
);

  // Input register.
  logic                            s1_valid;
  logic [1:0]                      s1_mode;
  logic signed [VELOCITY_BITS-1:0] s1_velocity;
  logic [15:0]                     s1_gyro;
  logic [31:0]                     s1_now;

  logic             advance;
  logic             accept;
  vrc_pkg::state_t  state;
  vrc_pkg::state_t  state_next;
  vrc_pkg::result_t result;
  logic             clear_enable;
  logic             enable;
  logic [1:0]       level;

  // The word in the input register moves on whenever the output register is free or
  // being emptied this cycle; the input side stalls only behind a stuck result.
  assign advance   = s1_valid && (!out_valid || !out_stall);
  assign in_stall  = s1_valid && !advance;
  assign accept    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_mode     <= mode;
      s1_velocity <= velocity;
      s1_gyro     <= gyro_magnitude;
      s1_now      <= now_ms;
    end
  end

  vrc_step #(
    .VELOCITY_BITS(VELOCITY_BITS)
  ) u_step (
    .state          (state),
    .enable         (enable),
    .level          (level),
    .mode           (s1_mode),
    .velocity       (s1_velocity),
    .gyro_magnitude (s1_gyro),
    .now_ms         (s1_now),
    .state_next     (state_next),
    .clear_enable   (clear_enable),
    .result         (result)
  );

  vrc_state u_state (
    .clk          (clk),
    .rst          (rst),
    .step         (advance),
    .state_next   (state_next),
    .clear_enable (clear_enable),
    .cfg_we       (cfg_valid && cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .state        (state),
    .enable       (enable),
    .level        (level)
  );

  // Output register: holds the result word until the downstream side takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      ignored               <= result.ignored;
      set_active            <= result.set_active;
      set_started           <= result.set_started;
      rep_event             <= result.rep_event;
      rep_count             <= result.rep_count;
      total_time_ms         <= result.total_time_ms;
      rest_time_ms          <= result.rest_time_ms;
      peak_speed            <= result.peak_speed;
      zero_velocity_request <= result.zero_velocity_request;
    end
  end

  // A sample taken while disabled changes nothing and raises no event.
  a_ignored_quiet: assert property (@(posedge clk) disable iff (rst)
    out_valid && ignored |-> !set_started && !rep_event && !zero_velocity_request)
    else $error("ignored sample raised an event");

  // Repetitions are only counted inside a set.
  a_rep_in_set: assert property (@(posedge clk) disable iff (rst)
    out_valid && rep_event |-> set_active)
    else $error("rep counted outside a set");

  // A freshly started set reports cleared counters and no repetition.
  a_start_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && set_started |-> set_active && !rep_event && rep_count == 10'd0 &&
                                 total_time_ms == 32'd0)
    else $error("set start did not clear set state");

  // The input side only stalls behind a held word.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> s1_valid && out_valid && out_stall)
    else $error("input stalled without a blocked word");

endmodule
